// ===== rtl/ngd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngd_pkg
// Shared types and constants for the next greater distance core: sequencer
// states, the shift command of the stack cells and the fixed field widths.
// ----------------------------------------------------------------------------
package ngd_pkg;

    // Fixed widths of the stream fields.
    localparam int TEMP_W     = 16;
    localparam int IDX_W      = 5;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_PAD_W  = OUT_DATA_W - 2 * IDX_W;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_OVF,
        ST_FLUSH
    } t_state;

    // Shift command broadcast to every cell of the stack.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP
    } t_cell_op;

endpackage

// ===== rtl/ngd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngd_cell
// One stack cell: holds a sample and its position. On a push it takes the
// entry of the neighbor above, on a pop the entry of the neighbor below.
// ----------------------------------------------------------------------------
module ngd_cell
    import ngd_pkg::*;
#(
    parameter int VAL_W = 16,
    parameter int POS_W = 6
) (
    input  logic                    i_clk,
    input  t_cell_op                i_op,
    input  logic signed [VAL_W-1:0] i_above_val,
    input  logic        [POS_W-1:0] i_above_pos,
    input  logic signed [VAL_W-1:0] i_below_val,
    input  logic        [POS_W-1:0] i_below_pos,
    output logic signed [VAL_W-1:0] o_val,
    output logic        [POS_W-1:0] o_pos
);

    logic signed [VAL_W-1:0] r_val;
    logic        [POS_W-1:0] r_pos;

    // Shift toward the bottom on a push, toward the top on a pop.
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_PUSH: begin
                r_val <= i_above_val;
                r_pos <= i_above_pos;
            end
            OP_POP: begin
                r_val <= i_below_val;
                r_pos <= i_below_pos;
            end
            default: begin
                r_val <= r_val;
                r_pos <= r_pos;
            end
        endcase
    end

    assign o_val = r_val;
    assign o_pos = r_pos;

endmodule

// ===== rtl/next_greater_distance_core.sv =====
`timescale 1ns / 1ps
// Sequencing: an item is taken in, then pops each entry that it resolves and then
// pushes itself; each result goes out through a register, and a pop waits while the output stalls.
// The block takes no new sample until the last one is through. Every sample is taken in
// once and, unless dropped, pushed once and later popped or flushed once via the cell chain;
// a final sample also flushes the stack to clear the run. Reset is synchronous and active
// low; it empties the stack and the output stage, the cell contents are left as is.
// ----------------------------------------------------------------------------
// next_greater_distance_core
// Streaming next greater element engine built on a shifting chain of stack
// cells, with cell 0 as the top of the stack.
// ----------------------------------------------------------------------------
module next_greater_distance_core
    import ngd_pkg::*;
#(
    parameter int MAX_DAYS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [TEMP_W-1:0]     i_s_axis_tdata,   // [15:0] temperature
    input  logic                  i_s_axis_tlast,   // last_day
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [4:0] day_index, [9:5] wait_days
    output logic                  o_m_axis_tlast,   // end_of_run
    output logic                  o_m_axis_tuser    // overflow
);

    localparam int CNT_W = $clog2(MAX_DAYS + 1);

    t_state r_state, n_state;
    t_cell_op w_op;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_last;
    logic        [CNT_W-1:0]       r_count, n_count;
    logic        [CNT_W-1:0]       r_day, n_day;

    logic signed [SAMPLE_BITS-1:0] w_val [MAX_DAYS];
    logic        [CNT_W-1:0]       w_pos [MAX_DAYS];

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_pop_hit;
    logic                          w_next_hit;
    logic                          w_emit;
    logic        [CNT_W-1:0]       w_emit_idx;
    logic        [CNT_W-1:0]       w_emit_wait;
    logic                          w_emit_eor;
    logic                          w_emit_ovf;
    logic        [CNT_W+IDX_W-1:0] w_idx_ext;
    logic        [CNT_W+IDX_W-1:0] w_wait_ext;
    logic [SAMPLE_BITS+TEMP_W-1:0] w_temp_ext;

    logic                          r_m_valid;
    logic        [IDX_W-1:0]       r_m_idx;
    logic        [IDX_W-1:0]       r_m_wait;
    logic                          r_m_eor;
    logic                          r_m_ovf;

    // Input handshake: one item at a time.
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_m_valid || i_m_axis_tready;

    // Sample taken from the low SAMPLE_BITS bits of the field.
    assign w_temp_ext = (SAMPLE_BITS + TEMP_W)'(i_s_axis_tdata);

    // The top two stack entries are tested against the held sample.
    assign w_pop_hit  = (r_count != '0) && (r_sample > w_val[0]);
    assign w_next_hit = (r_count > CNT_W'(1)) && (r_sample > w_val[1]);

    // Chain of stack cells.
    for (genvar g = 0; g < MAX_DAYS; g++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] w_above_val, w_below_val;
        logic        [CNT_W-1:0]       w_above_pos, w_below_pos;

        if (g == 0) begin : g_top
            assign w_above_val = r_sample;
            assign w_above_pos = r_day;
        end else begin : g_mid
            assign w_above_val = w_val[g-1];
            assign w_above_pos = w_pos[g-1];
        end

        if (g == MAX_DAYS - 1) begin : g_bottom
            assign w_below_val = w_val[g];
            assign w_below_pos = w_pos[g];
        end else begin : g_inner
            assign w_below_val = w_val[g+1];
            assign w_below_pos = w_pos[g+1];
        end

        ngd_cell #(
            .VAL_W (SAMPLE_BITS),
            .POS_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_above_val (w_above_val),
            .i_above_pos (w_above_pos),
            .i_below_val (w_below_val),
            .i_below_pos (w_below_pos),
            .o_val       (w_val[g]),
            .o_pos       (w_pos[g])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (r_day >= CNT_W'(MAX_DAYS)) ? ST_OVF : ST_POP;
                end
            end
            ST_POP: begin
                if (!w_pop_hit) begin
                    n_state = r_last ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_OVF: begin
                if (w_out_free) begin
                    n_state = r_last ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (r_count == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: result transfer, cell command and counters.
    always_comb begin
        w_emit      = 1'b0;
        w_emit_idx  = '0;
        w_emit_wait = '0;
        w_emit_eor  = 1'b0;
        w_emit_ovf  = 1'b0;
        w_op        = OP_HOLD;
        n_count     = r_count;
        n_day       = r_day;
        unique case (r_state)
            ST_POP: begin
                if (w_pop_hit) begin
                    if (w_out_free) begin
                        w_emit      = 1'b1;
                        w_emit_idx  = w_pos[0];
                        w_emit_wait = r_day - w_pos[0];
                        w_emit_eor  = !r_last && !w_next_hit;
                        w_op        = OP_POP;
                        n_count     = r_count - CNT_W'(1);
                    end
                end else begin
                    w_op    = OP_PUSH;
                    n_count = r_count + CNT_W'(1);
                    n_day   = r_day + CNT_W'(1);
                end
            end
            ST_OVF: begin
                if (w_out_free) begin
                    w_emit     = 1'b1;
                    w_emit_ovf = 1'b1;
                    w_emit_eor = !r_last || (r_count == '0);
                end
            end
            ST_FLUSH: begin
                if (r_count != '0) begin
                    if (w_out_free) begin
                        w_emit     = 1'b1;
                        w_emit_idx = w_pos[0];
                        w_emit_eor = (r_count == CNT_W'(1));
                        w_op       = OP_POP;
                        n_count    = r_count - CNT_W'(1);
                    end
                end else begin
                    n_day = '0;
                end
            end
            default: begin
                w_op = OP_HOLD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_day     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_day   <= n_day;
            if (w_emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Held input item.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= w_temp_ext[SAMPLE_BITS-1:0];
            r_last   <= i_s_axis_tlast;
        end
    end

    // Result register, narrowed to the five bit output fields.
    assign w_idx_ext  = (CNT_W + IDX_W)'(w_emit_idx);
    assign w_wait_ext = (CNT_W + IDX_W)'(w_emit_wait);

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_m_idx  <= w_idx_ext[IDX_W-1:0];
            r_m_wait <= w_wait_ext[IDX_W-1:0];
            r_m_eor  <= w_emit_eor;
            r_m_ovf  <= w_emit_ovf;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_m_wait, r_m_idx};
    assign o_m_axis_tlast  = r_m_eor;
    assign o_m_axis_tuser  = r_m_ovf;

endmodule

// ===== rtl/ngd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngd_checker
// Port level checks for the next greater distance core, bound to the top.
// ----------------------------------------------------------------------------
module ngd_checker
    import ngd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [4:0] day_index, [9:5] wait_days
    input logic                  o_m_axis_tlast,   // end_of_run
    input logic                  o_m_axis_tuser    // overflow
);

    // The block is ready for a sample right after reset.
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_s_axis_tready)
        else $error("input not ready after reset");

    // A sample transfer always takes the input out of the ready state.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second sample taken before the first was processed");

    // A stalled result keeps its content.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
             && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

    // A dropped sample reports neither a position nor a distance.
    a_overflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[9:0] == 10'd0))
        else $error("overflow result carries index or distance");

endmodule

bind next_greater_distance_core ngd_checker u_ngd_checker (.*);

// ===== bench/next_greater_distance_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_greater_distance_core_tb
// Self-checking bench for the next greater distance core. It streams runs of
// signed samples into the core with random gaps and stalls the result side at
// random. A behavioral stack predicts every result. A scoreboard compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
module next_greater_distance_core_tb;
    import ngd_pkg::*;

    localparam int MAX_DAYS     = 32;
    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_ITEMS = 370;
    localparam int DRAIN_CYCLES = 80;
    localparam int PLAN_LEN     = 18;
    localparam int REPORT_MAX   = 10;

    // Kinds of sample runs used by the random part.
    typedef enum int {
        RUN_NOISE,
        RUN_NARROW,
        RUN_FALLING
    } t_run_style;

    // One result of the core, in field order.
    typedef struct packed {
        logic [IDX_W-1:0] day_index;
        logic [IDX_W-1:0] wait_days;
        logic             end_of_run;
        logic             overflow;
    } t_day_result;

    // Tracks pending samples and the results they are due to produce.
    class wait_scoreboard;
        logic signed [TEMP_W-1:0] open_temps [MAX_DAYS];
        logic [IDX_W-1:0]         open_days [MAX_DAYS];
        int                       open_count;
        int                       day_count;
        t_day_result              awaited_results [$];
        int                       mismatches;
        int                       results_seen;
        int                       samples_seen;
        int                       overflows_seen;
        int                       runs_closed;

        // Works out the results caused by one accepted sample.
        function void note_sample(logic signed [TEMP_W-1:0] temp, logic last_day);
            t_day_result res;
            int          first;
            first = awaited_results.size();
            samples_seen++;
            res = '0;
            if (day_count >= MAX_DAYS) begin
                // A run that is already full drops the sample.
                res.overflow = 1'b1;
                awaited_results.push_back(res);
            end else begin
                // Resolve every pending sample that is strictly lower.
                while (open_count > 0 && temp > open_temps[open_count-1]) begin
                    open_count--;
                    res.day_index = open_days[open_count];
                    res.wait_days = IDX_W'(day_count - open_days[open_count]);
                    awaited_results.push_back(res);
                end
                if (open_count < MAX_DAYS) begin
                    open_temps[open_count] = temp;
                    open_days[open_count]  = IDX_W'(day_count);
                    open_count++;
                end
                day_count++;
            end
            if (last_day) begin
                // Leftovers go out newest first with no distance.
                res = '0;
                while (open_count > 0) begin
                    open_count--;
                    res.day_index = open_days[open_count];
                    awaited_results.push_back(res);
                end
                day_count = 0;
                runs_closed++;
            end
            if (awaited_results.size() > first) begin
                res = awaited_results.pop_back();
                res.end_of_run = 1'b1;
                awaited_results.push_back(res);
            end
        endfunction

        // Compares one result transfer with the oldest awaited result.
        function void check_result(t_day_result got);
            t_day_result want;
            results_seen++;
            if (got.overflow === 1'b1) overflows_seen++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] unexpected result: index %0d wait %0d end %b ovf %b",
                             $realtime, got.day_index, got.wait_days,
                             got.end_of_run, got.overflow);
                return;
            end
            want = awaited_results.pop_front();
            if (got.day_index !== want.day_index || got.wait_days !== want.wait_days ||
                got.end_of_run !== want.end_of_run || got.overflow !== want.overflow) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"[%0t] result mismatch: expected index %0d wait %0d end %b ",
                              "ovf %b, got index %0d wait %0d end %b ovf %b"},
                             $realtime, want.day_index, want.wait_days, want.end_of_run,
                             want.overflow, got.day_index, got.wait_days,
                             got.end_of_run, got.overflow);
            end
        endfunction
    endclass

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [TEMP_W-1:0]     s_data  = '0;
    logic                  s_last  = 1'b0;
    logic                  m_ready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  o_m_axis_tuser;

    wait_scoreboard board = new;
    int             cycle_count   = 0;
    int             random_items  = 0;
    int             rx_phase_left = 0;
    int             rx_stall_left = 0;
    bit             rx_steady     = 1'b0;

    next_greater_distance_core #(
        .MAX_DAYS   (MAX_DAYS),
        .SAMPLE_BITS(TEMP_W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),           // [15:0] temperature
        .i_s_axis_tlast (s_last),           // last_day
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata),   // [4:0] day_index, [9:5] wait_days
        .o_m_axis_tlast (o_m_axis_tlast),   // end_of_run
        .o_m_axis_tuser (o_m_axis_tuser)    // overflow
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Hard stop in case the core hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("next_greater_distance_core_tb NOT OK");
            $finish;
        end
    end

    // Result side: phases of steady readiness alternate with random stalls.
    always @(posedge i_clk) begin : rx_pacing
        int roll;
        if (rx_phase_left == 0) begin
            rx_phase_left = $urandom_range(40, 400);
            rx_steady     = ($urandom_range(0, 3) == 0);
        end else begin
            rx_phase_left--;
        end
        if (rx_steady) begin
            m_ready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else begin
            m_ready <= 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 25)
                rx_stall_left = $urandom_range(1, 3);
            else if (roll < 28)
                rx_stall_left = $urandom_range(15, 60);
        end
    end

    // Every accepted result transfer goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready)
            board.check_result(t_day_result'({o_m_axis_tdata[IDX_W-1:0],
                                              o_m_axis_tdata[2*IDX_W-1:IDX_W],
                                              o_m_axis_tlast, o_m_axis_tuser}));
    end

    // Presents one sample and waits for its transfer.
    task automatic send_sample(input logic signed [TEMP_W-1:0] temp, input logic last_day);
        s_valid <= 1'b1;
        s_data  <= temp;
        s_last  <= last_day;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_sample(temp, last_day);
    endtask

    // Optional pause on the sample side, mostly short and now and then long.
    task automatic idle_gap(input bit steady);
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends one complete run of samples, the final one marked as last.
    task automatic send_run(input int len, input t_run_style style, input bit steady);
        logic signed [TEMP_W-1:0] temp;
        int                       k;
        temp = TEMP_W'($urandom_range(20000, 32000));
        for (k = 0; k < len; k++) begin
            case (style)
                RUN_NOISE: begin
                    temp = TEMP_W'($urandom);
                end
                RUN_NARROW: begin
                    // A narrow value range gives many equal samples.
                    temp = TEMP_W'(int'($urandom_range(0, 7)) - 4);
                end
                default: begin
                    // Falling samples pile up, a peak at the end resolves them all unless the run is already full.
                    if (k == len - 1)
                        temp = 16'sh7fff;
                    else
                        temp = temp - TEMP_W'($urandom_range(0, 100));
                end
            endcase
            send_sample(temp, k == len - 1);
            random_items++;
            idle_gap(steady);
        end
    endtask

    initial begin : stimulus
        logic signed [TEMP_W-1:0] plan_temps [PLAN_LEN];
        bit                       plan_last [PLAN_LEN];
        int                       run_no;
        int                       roll;
        int                       len;
        t_run_style               style;
        int                       k;

        // Single sample, extremes, equal samples, falling, rising, mixed sign.
        plan_temps = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd5, 16'sd5, 16'sd5, 16'sd6,
                       16'sd10, 16'sd9, 16'sd8, 16'sd7, 16'sd1, 16'sd2, 16'sd3, 16'sd4,
                       16'sd32767, -16'sd32768, -16'sd1};
        plan_last  = '{1, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < PLAN_LEN; k++) begin
            send_sample(plan_temps[k], plan_last[k]);
            idle_gap(1'b0);
        end

        // Random runs; the first ones reach the longest wait and the overflow cases.
        run_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (run_no == 0) begin
                len   = MAX_DAYS;
                style = RUN_FALLING;
            end else if (run_no == 1) begin
                len   = MAX_DAYS + 3;
                style = RUN_NOISE;
            end else if (run_no == 2) begin
                len   = MAX_DAYS + 4;
                style = RUN_FALLING;
            end else begin
                if (roll < 80)
                    len = $urandom_range(1, 10);
                else if (roll < 90)
                    len = $urandom_range(11, MAX_DAYS - 1);
                else
                    len = $urandom_range(MAX_DAYS, MAX_DAYS + 4);
                style = t_run_style'($urandom_range(0, 2));
            end
            send_run(len, style, $urandom_range(0, 4) == 0);
            run_no++;
        end
        s_valid <= 1'b0;

        // Drain the remaining results, then watch for strays.
        while (board.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d samples in %0d runs; checked %0d results, %0d of them overflows.",
                 board.samples_seen, board.runs_closed, board.results_seen,
                 board.overflows_seen);
        $display("Mismatches: %0d, results still awaited: %0d.",
                 board.mismatches, board.awaited_results.size());
        if (board.mismatches == 0 && board.awaited_results.size() == 0) begin
            $display("next_greater_distance_core_tb OK");
        end else begin
            $display("next_greater_distance_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ngd_pkg.sv
rtl/ngd_cell.sv
rtl/next_greater_distance_core.sv
rtl/ngd_checker.sv
bench/next_greater_distance_core_tb.sv
